>>> design/sha256_stream_hasher_top_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the sha-256 stream hasher
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// implication checked on the same edge
`define SHS_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("shs check failed");
// implication checked on the next edge
`define SHS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("shs check failed");
`else
`define SHS_ASSERT_IMP(label, pre, post)
`define SHS_ASSERT_NEXT(label, pre, post)
`endif

`endif

>>> design/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// types, constants and round functions of the sha-256 stream hasher
// ----------------------------------------------------------------------------
package shs_pkg;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PREP  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FINAL = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // source of the sixteen message words of the block being compressed
    typedef enum logic [1:0] {
        BLK_DATA    = 2'd0,
        BLK_PAD     = 2'd1,
        BLK_PAD_LEN = 2'd2,
        BLK_LEN     = 2'd3
    } blk_mode_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] PAD_LIMIT = 6'd55;

    // initial hash values
    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    // round constants
    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // word holding the pending bytes, the pad byte and zeros
    function automatic logic [31:0] pad_word(input logic [23:0] acc, input logic [1:0] k);
        logic [31:0] v;
        unique case (k)
            2'd0: v = {PAD_BYTE, 24'h0};
            2'd1: v = {acc[7:0], PAD_BYTE, 16'h0};
            2'd2: v = {acc[15:0], PAD_BYTE, 8'h0};
            default: v = {acc[23:0], PAD_BYTE};
        endcase
        return v;
    endfunction

endpackage

>>> design/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// byte-serial sha-256 hasher with a word memory for the block buffer
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry data_byte, byte_present and
// end_of_message. A request with byte_present set appends data_byte; one with
// end_of_message set closes the message (after its byte, if any).
// Output channel: out_valid / out_stall carry eight digest words, word 0
// first, digest_index counting 0..7 and last_word set on word 7.
// Bytes are taken one per cycle while no block is being compressed. Every
// 64th byte starts a compression: a read of the first block word (ST_PREP),
// 64 rounds at one round per cycle (ST_ROUND), then an add into the chaining
// words (ST_FINAL); in_stall is high throughout, so no byte is taken meanwhile.
// At end of message one or two padded blocks follow, then the eight words
// leave at one per cycle, longer while out_stall is high.
// The round loop and the single read port of the block memory set the rate.
// Input is stalled until the last digest word is taken; the hash, the byte
// and bit counts then return to their reset values and a new message may start.
// Reset (rst_n low) restores the initial hash, clears the byte and bit
// counts and drops out_valid; the block memory needs no clearing.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_top_defines.svh"

module sha256_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        last_word
);
    import shs_pkg::*;

    state_t      state_reg, state_next;
    blk_mode_t   mode_reg, mode_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [23:0] acc_reg;
    logic        end_reg, end_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  ocnt_reg, ocnt_next;
    logic [31:0] hash_reg [8];
    logic [31:0] var_reg [8];
    logic [31:0] w_reg [16];

    logic [31:0] blk_mem [16];
    logic [31:0] rdata;
    logic [3:0]  raddr;
    logic        mem_we;
    logic [31:0] mem_wdata;

    logic        in_acc;
    logic        out_acc;
    logic [5:0]  fill_inc;
    logic [31:0] word_in;
    logic [31:0] w_cur;
    logic [31:0] t1, t2;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign digest_word = hash_reg[ocnt_reg];
    assign digest_index = ocnt_reg;
    assign last_word = (ocnt_reg == 3'd7);

    // byte packing into words of the block memory
    assign fill_inc  = fill_reg + 6'd1;
    assign mem_wdata = {acc_reg, data_byte};
    assign mem_we    = in_acc && byte_present && (fill_reg[1:0] == 2'd3);

    // block memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            blk_mem[fill_reg[5:2]] <= mem_wdata;
        end
        rdata <= blk_mem[raddr];
    end

    // next word to read during the first sixteen rounds
    always_comb
    begin
        raddr = 4'd0;
        if (state_reg == ST_ROUND)
        begin
            raddr = rnd_reg[3:0] + 4'd1;
        end
    end

    // message word of the first sixteen rounds, padding merged in
    always_comb
    begin
        word_in = 32'h0;
        unique case (mode_reg)
            BLK_DATA: word_in = rdata;
            BLK_PAD, BLK_PAD_LEN:
            begin
                if (rnd_reg[3:0] < fill_reg[5:2])
                    word_in = rdata;
                else if (rnd_reg[3:0] == fill_reg[5:2])
                    word_in = pad_word(acc_reg, fill_reg[1:0]);
                else if (mode_reg == BLK_PAD_LEN && rnd_reg[3:0] == 4'd14)
                    word_in = bits_reg[63:32];
                else if (mode_reg == BLK_PAD_LEN && rnd_reg[3:0] == 4'd15)
                    word_in = bits_reg[31:0];
                else
                    word_in = 32'h0;
            end
            default:
            begin
                if (rnd_reg[3:0] == 4'd14)
                    word_in = bits_reg[63:32];
                else if (rnd_reg[3:0] == 4'd15)
                    word_in = bits_reg[31:0];
                else
                    word_in = 32'h0;
            end
        endcase
    end

    // round datapath
    always_comb
    begin
        if (rnd_reg[5:4] == 2'd0)
            w_cur = word_in;
        else
            w_cur = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
        t1 = var_reg[7] + big_sigma1(var_reg[4])
           + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
           + round_const(rnd_reg) + w_cur;
        t2 = big_sigma0(var_reg[0])
           + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2]) ^ (var_reg[1] & var_reg[2]));
    end

    // controller
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        end_next   = end_reg;
        rnd_next   = rnd_reg;
        ocnt_next  = ocnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (byte_present)
                    begin
                        fill_next = fill_inc;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (byte_present && fill_reg == 6'd63)
                    begin
                        mode_next  = BLK_DATA;
                        end_next   = end_of_message;
                        state_next = ST_PREP;
                    end
                    else if (end_of_message)
                    begin
                        mode_next  = (fill_next > PAD_LIMIT) ? BLK_PAD : BLK_PAD_LEN;
                        end_next   = 1'b0;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                rnd_next   = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                priority if (mode_reg == BLK_DATA && end_reg)
                begin
                    mode_next  = BLK_PAD_LEN;
                    end_next   = 1'b0;
                    state_next = ST_PREP;
                end
                else if (mode_reg == BLK_DATA)
                    state_next = ST_IDLE;
                else if (mode_reg == BLK_PAD)
                begin
                    mode_next  = BLK_LEN;
                    state_next = ST_PREP;
                end
                else
                begin
                    ocnt_next  = 3'd0;
                    state_next = ST_OUT;
                end
            end
            default:
            begin
                if (out_acc)
                begin
                    ocnt_next = ocnt_reg + 3'd1;
                    if (ocnt_reg == 3'd7)
                    begin
                        fill_next  = 6'd0;
                        bits_next  = 64'd0;
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= BLK_DATA;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
            end_reg   <= 1'b0;
            rnd_reg   <= 6'd0;
            ocnt_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            end_reg   <= end_next;
            rnd_reg   <= rnd_next;
            ocnt_reg  <= ocnt_next;
        end
    end

    // chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= init_hash(3'(i));
        end
        else if (state_reg == ST_FINAL)
        begin
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= hash_reg[i] + var_reg[i];
        end
        else if (out_acc && last_word)
        begin
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= init_hash(3'(i));
        end
    end

    // working variables, schedule shift line and byte packer
    always_ff @(posedge clk)
    begin
        if (in_acc && byte_present)
            acc_reg <= mem_wdata[23:0];
        if (state_reg == ST_PREP)
        begin
            for (int i = 0; i < 8; i++)
                var_reg[i] <= hash_reg[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_cur;
        end
    end

    // checks
    `SHS_ASSERT_IMP(a_no_input_during_output, out_valid, in_stall)
    `SHS_ASSERT_NEXT(a_full_block_compresses,
        in_acc && byte_present && fill_reg == 6'd63, state_reg == ST_PREP)
    `SHS_ASSERT_NEXT(a_last_word_ends_digest, out_acc && last_word, !out_valid && !in_stall)

endmodule
